[sv/integer_to_text_formatter_core_macros.svh]
// Assertion macros shared by the formatter checker.
`ifndef INTEGER_TO_TEXT_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_TEXT_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define ITF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itf checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define ITF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itf checker: next-cycle property failed");

`endif

[sv/itf_pkg.sv]
// Types, constants and helper functions of the integer to text formatter.
package itf_pkg;

	localparam int VALUE_W  = 32;
	localparam int RADIX_W  = 6;
	localparam int FIELD_W  = 6;
	localparam int DIV_STEP = 4;
	localparam int POS_W    = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
	localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_X_LO  = 8'h78;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               signed_mode;
		logic [RADIX_W-1:0] radix;
		logic [FIELD_W-1:0] min_width;
		logic [FIELD_W-1:0] min_digits;
		logic               left_justify;
		logic               zero_pad;
		logic               force_plus;
		logic               space_sign;
		logic               alt_prefix;
		logic               lower_case;
	} itf_in_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} itf_out_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic store;
		logic calc;
		logic emit;
	} itf_cmd_t;

	typedef struct packed {
		logic div_last;
		logic conv_done;
		logic emit_last;
	} itf_sts_t;

	// Map a digit value to its ASCII character; values wrap modulo 36.
	function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d, input logic lower);
		logic [RADIX_W-1:0] dm;
		dm = (d >= RADIX_MAX) ? d - RADIX_MAX : d;
		if (dm < 6'd10) begin
			return CH_ZERO + {2'b00, dm};
		end else if (lower) begin
			return CH_A_LO + {2'b00, dm - 6'd10};
		end else begin
			return CH_A_UP + {2'b00, dm - 6'd10};
		end
	endfunction

endpackage

[sv/itf_ctrl.sv]
// Sequencer of the formatter: divide, store digits, lay out, emit.
module itf_ctrl
	import itf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  itf_sts_t sts,
	output itf_cmd_t cmd,
	output logic     busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_STORE = 3'd2;
	localparam logic [2:0] S_CALC  = 3'd3;
	localparam logic [2:0] S_FETCH = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start) state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_STORE;
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d   = sts.conv_done ? S_CALC : S_DIV;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_FETCH;
			end
			S_FETCH: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_last) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

[sv/itf_dp.sv]
// Datapath of the formatter: digit divider, digit memory, layout and character mux.
module itf_dp
	import itf_pkg::*;
#(
	parameter int DIGIT_DEPTH = 32,
	parameter int MAX_WIDTH   = 63
) (
	input  logic     clk,
	input  logic     arst_n,
	input  itf_in_t  request,
	input  itf_cmd_t cmd,
	output itf_sts_t sts,
	output itf_out_t result,
	output logic     strobe
);

	localparam int AW    = $clog2(DIGIT_DEPTH);
	localparam int DCW   = $clog2(DIGIT_DEPTH + 1);
	localparam int STEPS = VALUE_W / DIV_STEP;
	localparam int SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;

	// format fields held for the item
	logic [7:0]         sign_ch_q;
	logic               has_sign_q;
	logic [1:0]         pfx_len_q;
	logic               lower_q;
	logic               left_q;
	logic               zpad_q;
	logic [FIELD_W-1:0] width_q;
	logic [POS_W-1:0]   prec_q;
	logic [RADIX_W-1:0] radix_q;

	// divider
	logic [VALUE_W-1:0] work_q;
	logic [RADIX_W-1:0] part_q;
	logic [SCW-1:0]     step_q;
	logic [DCW-1:0]     dcnt_q;
	logic [VALUE_W-1:0] work_d;
	logic [RADIX_W-1:0] part_d;

	// layout boundaries
	logic [POS_W-1:0] b_lead_q;
	logic [POS_W-1:0] b_sign_q;
	logic [POS_W-1:0] b_pfx0_q;
	logic [POS_W-1:0] b_pfxx_q;
	logic [POS_W-1:0] b_prec_q;
	logic [POS_W-1:0] b_dig_q;
	logic [POS_W-1:0] tot_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_d;

	logic [RADIX_W-1:0] mem [DIGIT_DEPTH];
	logic [RADIX_W-1:0] rd_q;
	logic [POS_W-1:0]   rd_addr;

	logic [7:0] char_c;
	itf_out_t   result_q;
	logic       strobe_q;

	// request decode
	logic [RADIX_W-1:0] radix_c;
	logic [VALUE_W-1:0] mag_c;
	logic               neg_c;
	logic [POS_W-1:0]   prec_c;

	always_comb begin
		radix_c = request.radix;
		if (request.radix < RADIX_MIN) radix_c = RADIX_MIN;
		if (request.radix > RADIX_MAX) radix_c = RADIX_MAX;
		neg_c  = request.signed_mode & request.value[VALUE_W-1];
		mag_c  = neg_c ? (~request.value + VALUE_W'(1)) : request.value;
		prec_c = ({1'b0, request.min_digits} > POS_W'(DIGIT_DEPTH)) ?
			POS_W'(DIGIT_DEPTH) : {1'b0, request.min_digits};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			has_sign_q <= neg_c | request.force_plus | request.space_sign;
			if (neg_c) sign_ch_q <= CH_MINUS;
			else if (request.force_plus) sign_ch_q <= CH_PLUS;
			else sign_ch_q <= CH_SPACE;
			if (request.alt_prefix && radix_c == RADIX_HEX) pfx_len_q <= 2'd2;
			else if (request.alt_prefix && radix_c == RADIX_OCT) pfx_len_q <= 2'd1;
			else pfx_len_q <= 2'd0;
			lower_q <= request.lower_case;
			left_q  <= request.left_justify;
			zpad_q  <= request.zero_pad & ~request.left_justify;
			width_q <= request.min_width;
			prec_q  <= prec_c;
			radix_q <= radix_c;
		end
	end

	// Long division by the radix, DIV_STEP quotient bits per cycle while cmd.div_step is high.
	always_comb begin
		logic [RADIX_W:0]   r;
		logic [VALUE_W-1:0] w;
		r = {1'b0, part_q};
		w = work_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			r = {r[RADIX_W-1:0], w[VALUE_W-1]};
			w = {w[VALUE_W-2:0], 1'b0};
			if (r >= {1'b0, radix_q}) begin
				r    = r - {1'b0, radix_q};
				w[0] = 1'b1;
			end
		end
		work_d = w;
		part_d = r[RADIX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= mag_c;
		end else if (cmd.div_step) begin
			work_q <= work_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			step_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.load) begin
			part_q <= '0;
			step_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			part_q <= part_d;
			step_q <= step_q + SCW'(1);
		end else if (cmd.store) begin
			part_q <= '0;
			dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[dcnt_q[AW-1:0]] <= part_q;
		end
	end

	assign sts.div_last  = (step_q == SCW'(STEPS - 1));
	assign sts.conv_done = (work_q == '0) || (dcnt_q == DCW'(DIGIT_DEPTH - 1));

	// Layout: cumulative segment ends on the output position.
	always_ff @(posedge clk) begin
		logic [POS_W-1:0] digits;
		logic [POS_W-1:0] prec;
		logic [POS_W-1:0] used;
		logic [POS_W-1:0] pad;
		logic [POS_W-1:0] lead;
		logic [POS_W-1:0] zp;
		logic [POS_W-1:0] trail;
		logic [POS_W-1:0] sgn;
		logic [POS_W-1:0] pend;
		digits = POS_W'(dcnt_q);
		prec   = (prec_q > digits) ? prec_q : digits;
		used   = POS_W'(has_sign_q) + POS_W'(pfx_len_q) + prec;
		pad    = ({1'b0, width_q} > used) ? {1'b0, width_q} - used : '0;
		lead   = (!left_q && !zpad_q) ? pad : '0;
		zp     = zpad_q ? pad : '0;
		trail  = left_q ? pad : '0;
		sgn    = lead + POS_W'(has_sign_q);
		pend   = sgn + POS_W'(pfx_len_q) + zp + prec + trail;
		if (cmd.calc) begin
			b_lead_q <= lead;
			b_sign_q <= sgn;
			b_pfx0_q <= sgn + POS_W'(pfx_len_q != 2'd0);
			b_pfxx_q <= sgn + POS_W'(pfx_len_q);
			b_prec_q <= sgn + POS_W'(pfx_len_q) + zp + (prec - digits);
			b_dig_q  <= sgn + POS_W'(pfx_len_q) + zp + prec;
			tot_q    <= (pend > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : pend;
		end
	end

	assign pos_d = cmd.emit ? pos_q + POS_W'(1) : pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.calc) begin
			pos_q <= '0;
		end else begin
			pos_q <= pos_d;
		end
	end

	// Prefetch the digit for the next position; digits come out top first.
	assign rd_addr = b_dig_q - POS_W'(1) - pos_d;

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr[AW-1:0]];
	end

	always_comb begin
		priority if (pos_q < b_lead_q) char_c = CH_SPACE;
		else if (pos_q < b_sign_q) char_c = sign_ch_q;
		else if (pos_q < b_pfx0_q) char_c = CH_ZERO;
		else if (pos_q < b_pfxx_q) char_c = lower_q ? CH_X_LO : CH_X_UP;
		else if (pos_q < b_prec_q) char_c = CH_ZERO;
		else if (pos_q < b_dig_q) char_c = digit_char(rd_q, lower_q);
		else char_c = CH_SPACE;
	end

	assign sts.emit_last = (pos_q == tot_q - POS_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.character <= char_c;
			result_q.last      <= sts.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

[sv/integer_to_text_formatter_core.sv]
// Top level of the printf-style integer to text formatter.
// Usage:
//   Drive request with a number and its format, raise start. The request
//   beat is taken at the rising edge where start is high and busy is low;
//   busy then stays high until the last character has been generated.
//   Characters leave one per beat on result, each valid for exactly one
//   cycle while strobe is high; result.last marks the final one.
// Sequence of an item:
//   the digits are generated one at a time by the shared divider, which
//   retires four quotient bits a cycle and stores each digit after its last
//   step; then the text is laid out and the top digit prefetched.
//   The characters follow back to back, one per cycle, until the last one.
// Reset: arst_n clears the sequencer, counters and strobe; no item is in
//   flight afterwards. The digit memory needs no clearing.
// The receiver cannot stall: every strobed beat is taken as it is shown.
module integer_to_text_formatter_core
	import itf_pkg::*;
#(
	parameter int DIGIT_DEPTH = 32,
	parameter int MAX_WIDTH   = 63
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  itf_in_t  request,
	output itf_out_t result,
	output logic     strobe
);

	itf_cmd_t cmd;
	itf_sts_t sts;

	// Sequencer: hold the step, advance on status from the datapath.
	itf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath: divider, digit memory, layout and registered output beat.
	itf_dp #(
		.DIGIT_DEPTH (DIGIT_DEPTH),
		.MAX_WIDTH   (MAX_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result),
		.strobe  (strobe)
	);

endmodule

[sv/itf_chk.sv]
// Port-level checker of the formatter and its bind to the top level.
`include "integer_to_text_formatter_core_macros.svh"

module itf_chk
	import itf_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input itf_in_t  request,
	input itf_out_t result,
	input logic     strobe
);

	// an accepted item turns busy on, and no beat follows right away
	`ITF_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !strobe)
	// a beat that is not the last one comes while work goes on
	`ITF_ASSERT_NOW(a_mid_beat_busy, strobe && !result.last, busy)
	// busy drops exactly when the final beat is shown
	`ITF_ASSERT_NOW(a_fall_on_last, $fell(busy), strobe && result.last)
	// nothing follows the final beat
	`ITF_ASSERT_NEXT(a_quiet_after_last, strobe && result.last, !strobe)

endmodule

bind integer_to_text_formatter_core itf_chk u_chk (.*);

[dv/integer_to_text_formatter_checker.sv]
// Checker for the integer to text formatter: predicts the text and compares each character beat.
module integer_to_text_formatter_checker
	import itf_pkg::*;
#(
	parameter int DIGIT_SLOTS = 32,
	parameter int MAX_CHARS   = 63
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  itf_in_t  request,
	input  itf_out_t result,
	input  logic     strobe,
	output int       mismatch_count,
	output int       chars_pending
);

	itf_out_t expected_chars[$];

	// Lay out the printf text of one request and queue its character beats.
	function automatic void format_number(input itf_in_t req);
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] base;
		logic [5:0]         digs [DIGIT_SLOTS];
		logic [7:0]         text [$];
		logic [7:0]         sign_ch;
		bit                 has_sign;
		bit                 lower;
		bit                 left;
		bit                 zpad;
		int                 prec;
		int                 used;
		int                 pad;
		int                 ndig;
		int                 prefix_len;
		int                 k;
		itf_out_t           beat;
		base = VALUE_W'(req.radix);
		if (base < RADIX_MIN) base = VALUE_W'(RADIX_MIN);
		if (base > RADIX_MAX) base = VALUE_W'(RADIX_MAX);
		left  = req.left_justify;
		zpad  = req.zero_pad && !left;
		lower = req.lower_case;
		prec  = int'(req.min_digits);
		if (prec > DIGIT_SLOTS) prec = DIGIT_SLOTS;

		mag      = req.value;
		has_sign = 1'b1;
		sign_ch  = CH_MINUS;
		if (req.signed_mode && req.value[VALUE_W-1]) begin
			mag = '0 - req.value;
		end else if (req.force_plus) begin
			sign_ch = CH_PLUS;
		end else if (req.space_sign) begin
			sign_ch = CH_SPACE;
		end else begin
			has_sign = 1'b0;
		end

		prefix_len = 0;
		if (req.alt_prefix && base == RADIX_HEX) prefix_len = 2;
		else if (req.alt_prefix && base == RADIX_OCT) prefix_len = 1;

		// digits come out least significant first
		ndig = 0;
		do begin
			digs[ndig] = 6'(mag % base);
			mag = mag / base;
			ndig++;
		end while (mag != 0 && ndig < DIGIT_SLOTS);

		if (ndig > prec) prec = ndig;
		used = int'(has_sign) + prefix_len + prec;
		pad  = (int'(req.min_width) > used) ? int'(req.min_width) - used : 0;

		if (!left && !zpad) repeat (pad) text.push_back(CH_SPACE);
		if (has_sign) text.push_back(sign_ch);
		if (prefix_len >= 1) text.push_back(CH_ZERO);
		if (prefix_len == 2) text.push_back(lower ? CH_X_LO : CH_X_UP);
		if (zpad) repeat (pad) text.push_back(CH_ZERO);
		repeat (prec - ndig) text.push_back(CH_ZERO);
		for (k = ndig - 1; k >= 0; k--) begin
			if (digs[k] < 6'd10) text.push_back(CH_ZERO + {2'b00, digs[k]});
			else text.push_back((lower ? CH_A_LO : CH_A_UP) + {2'b00, digs[k]} - 8'd10);
		end
		if (left) repeat (pad) text.push_back(CH_SPACE);

		// drop anything past the output limit; last marks the final kept beat
		for (k = 0; k < text.size() && k < MAX_CHARS; k++) begin
			beat.character = text[k];
			beat.last      = (k == text.size() - 1) || (k == MAX_CHARS - 1);
			expected_chars.push_back(beat);
		end
	endfunction

	always @(posedge clk) begin
		itf_out_t want;
		if (!arst_n) begin
			mismatch_count <= 0;
		end else begin
			if (strobe) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected beat, expected none actual char %h last %b",
						$time, result.character, result.last);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_chars.pop_front();
					if (result.character !== want.character || result.last !== want.last) begin
						$display("%0t: beat mismatch, expected char %h last %b actual char %h last %b",
							$time, want.character, want.last, result.character, result.last);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (start && !busy) format_number(request);
		end
		chars_pending <= expected_chars.size();
	end

endmodule

[dv/testbench.sv]
// Top of the formatter testbench: clock, reset, request stimulus, watchdog and verdict.
module testbench;
	import itf_pkg::*;

	localparam int DIGIT_DEPTH    = 32;
	localparam int MAX_WIDTH      = 63;
	// Slowest item: 32 binary digits plus 63 beats.
	localparam int DRAIN_CYCLES   = 400;
	// Quiet cycles allowed before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_GAP        = 40;
	localparam int RANDOM_ITEMS   = 250;
	localparam int IN_W           = $bits(itf_in_t);

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	itf_in_t  request;
	itf_out_t result;
	logic     strobe;
	int       mismatch_count;
	int       chars_pending;
	int       quiet_cycles;

	integer_to_text_formatter_core #(
		.DIGIT_DEPTH(DIGIT_DEPTH),
		.MAX_WIDTH  (MAX_WIDTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.request(request),
		.result(result),
		.strobe(strobe)
	);

	integer_to_text_formatter_checker #(
		.DIGIT_SLOTS(DIGIT_DEPTH),
		.MAX_CHARS  (MAX_WIDTH)
	) checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.request       (request),
		.result        (result),
		.strobe        (strobe),
		.mismatch_count(mismatch_count),
		.chars_pending (chars_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hang detector: reset the count on any accepted request or result beat.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Assemble a request from its fields; flags go left, zero, plus, space, alt, lower.
	function automatic itf_in_t make_request(input logic [31:0] value, input logic sgn,
			input int radix, input int width, input int prec, input logic [5:0] flags);
		itf_in_t r;
		r.value        = value;
		r.signed_mode  = sgn;
		r.radix        = RADIX_W'(radix);
		r.min_width    = FIELD_W'(width);
		r.min_digits   = FIELD_W'(prec);
		r.left_justify = flags[5];
		r.zero_pad     = flags[4];
		r.force_plus   = flags[3];
		r.space_sign   = flags[2];
		r.alt_prefix   = flags[1];
		r.lower_case   = flags[0];
		return r;
	endfunction

	// Draw a random request, weighted toward the common bases and short fields.
	function automatic itf_in_t random_request();
		itf_in_t r;
		int      pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2, 3: r.value = $urandom;
			4, 5:       r.value = $urandom_range(0, 999);
			6: begin
				case ($urandom_range(0, 3))
					0: r.value = 32'h0000_0000;
					1: r.value = 32'hFFFF_FFFF;
					2: r.value = 32'h8000_0000;
					default: r.value = 32'h7FFF_FFFF;
				endcase
			end
			7:       r.value = 32'd0 - $urandom_range(1, 1000);
			default: r.value = 32'd1 << $urandom_range(0, 31);
		endcase
		case ($urandom_range(0, 9))
			0:       r.radix = RADIX_MIN;
			1:       r.radix = RADIX_OCT;
			2, 3:    r.radix = RADIX_W'(10);
			4, 5:    r.radix = RADIX_HEX;
			6:       r.radix = RADIX_MAX;
			default: r.radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
		endcase
		// now and then an out-of-range base, which the block clamps
		if ($urandom_range(0, 49) == 0) r.radix = RADIX_W'($urandom_range(0, 63));
		r.min_width = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(0, 63))
			: FIELD_W'($urandom_range(0, 16));
		r.min_digits  = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(0, DIGIT_DEPTH))
			: FIELD_W'($urandom_range(0, 4));
		if ($urandom_range(0, 49) == 0) r.min_digits = FIELD_W'($urandom_range(0, 63));
		r.signed_mode  = 1'($urandom_range(0, 1));
		r.left_justify = 1'($urandom_range(0, 1));
		r.zero_pad     = 1'($urandom_range(0, 1));
		r.force_plus   = 1'($urandom_range(0, 1));
		r.space_sign   = 1'($urandom_range(0, 1));
		r.alt_prefix   = 1'($urandom_range(0, 1));
		r.lower_case   = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// Present one request beat; idle first with the given odds, then hold start until taken.
	task automatic issue_request(input itf_in_t req, input int idle_pct);
		int gap;
		gap = 0;
		@(negedge clk);
		while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
			start   = 1'b0;
			request = IN_W'({$urandom, $urandom});
			gap++;
			@(negedge clk);
		end
		request = req;
		start   = 1'b1;
		// busy is sampled before the edge updates it, so the beat is taken when this exits
		do @(posedge clk); while (busy);
	endtask

	initial begin
		int idle_by_phase [4];
		int phase;
		int n;
		idle_by_phase = '{0, 83, 31, 0};
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, each flag and the corner cases, back to back.
		issue_request(make_request(32'h0000_0000, 1'b0, 10, 0, 0, 6'b000000), 0);
		issue_request(make_request(32'h0000_0000, 1'b0, 16, 0, 0, 6'b000010), 0);
		issue_request(make_request(32'h0000_0000, 1'b0, 8, 5, 0, 6'b000010), 0);
		issue_request(make_request(32'h7FFF_FFFF, 1'b1, 10, 0, 0, 6'b001000), 0);
		issue_request(make_request(32'h8000_0000, 1'b1, 10, 0, 0, 6'b000000), 0);
		issue_request(make_request(32'hFFFF_FFFF, 1'b1, 10, 8, 0, 6'b010000), 0);
		issue_request(make_request(32'hFFFF_FFFF, 1'b0, 2, 0, 0, 6'b000000), 0);
		issue_request(make_request(32'hFFFF_FFFF, 1'b0, 36, 0, 0, 6'b000000), 0);
		issue_request(make_request(32'hFFFF_FFFF, 1'b0, 36, 0, 0, 6'b000001), 0);
		issue_request(make_request(32'hDEAD_BEEF, 1'b0, 16, 20, 0, 6'b010011), 0);
		issue_request(make_request(32'hDEAD_BEEF, 1'b0, 16, 20, 0, 6'b000010), 0);
		issue_request(make_request(32'd511, 1'b0, 8, 12, 0, 6'b001010), 0);
		// left justify cancels zero padding
		issue_request(make_request(32'd42, 1'b0, 10, 30, 0, 6'b110100), 0);
		issue_request(make_request(32'd42, 1'b0, 10, 6, 0, 6'b001100), 0);
		issue_request(make_request(32'hFFFF_FFF6, 1'b1, 10, 63, 32, 6'b000000), 0);
		issue_request(make_request(32'h0000_0000, 1'b0, 10, 63, 0, 6'b111111), 0);
		// precision beyond the digit store clamps
		issue_request(make_request(32'd7, 1'b0, 10, 0, 33, 6'b000000), 0);
		issue_request(make_request(32'd7, 1'b1, 16, 40, 63, 6'b001010), 0);
		// out-of-range bases act as the nearest limit
		issue_request(make_request(32'd1000, 1'b0, 0, 0, 0, 6'b000000), 0);
		issue_request(make_request(32'd1000, 1'b0, 1, 0, 0, 6'b000000), 0);
		issue_request(make_request(32'd123456, 1'b0, 37, 0, 0, 6'b000001), 0);
		issue_request(make_request(32'd123456, 1'b0, 63, 0, 0, 6'b000000), 0);
		// width too small: no padding, text not cut
		issue_request(make_request(32'd123456, 1'b0, 10, 3, 0, 6'b010000), 0);
		// a base with no alternate prefix
		issue_request(make_request(32'd1234, 1'b0, 5, 0, 0, 6'b000010), 0);

		// Random: split across idling phases, including two with no gaps at all.
		for (phase = 0; phase < 4; phase++) begin
			for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
				issue_request(random_request(), idle_by_phase[phase]);
			end
		end
		@(negedge clk);
		start = 1'b0;

		// Drain: let the accept register, wait out the text, then watch for stray beats.
		@(posedge clk);
		while (chars_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
